// ----- rtl/bit_packer_with_varint_write_top_macros.svh -----
// assertion macros for the bit packer with varint write
`ifndef BIT_PACKER_WITH_VARINT_WRITE_TOP_MACROS_SVH
`define BIT_PACKER_WITH_VARINT_WRITE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpv_pkg.sv -----
// shared types and constants of the bit packer with varint write
`default_nettype none

package bpv_pkg;

    localparam int MAX_CAPACITY = 65536;
    localparam int CAP_W        = 17;
    localparam int POS_W        = 17;

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_CAPACITY);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65536);
    localparam logic [5:0]       BITS_MAX  = 6'd32;

    typedef enum logic [1:0] {
        OP_BITS   = 2'd0,
        OP_VARINT = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_REWIND = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [5:0]  nbits;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] out_position;
        logic        status;
        logic        last;
    } result_t;

    // classified command between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] data;
        logic [5:0]  count;
    } cmd_t;

    // command queue head as seen by the back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

`default_nettype wire

// ----- rtl/bpv_front.sv -----
// front: classifies input items and queues commands for the back
`default_nettype none

module bpv_front
    import bpv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire item_t     item,
    output logic           full,
    output cmd_head_t      head,
    input  wire logic      head_pop
);

    logic [1:0]  count_reg;
    cmd_t        head_reg;
    cmd_t        tail_reg;

    logic [5:0]  clamped;
    logic [63:0] aligned_wide;
    cmd_t        cmd_in;
    logic        do_push;
    logic        do_pop;

    // clamp the bit count and left-align the bits to append
    always_comb
    begin
        clamped      = (item.nbits > BITS_MAX) ? BITS_MAX : item.nbits;
        aligned_wide = {item.value, 32'b0} >> clamped;
        cmd_in.op    = op_t'(item.kind);
        cmd_in.count = clamped;
        cmd_in.data  = (op_t'(item.kind) == OP_BITS) ? aligned_wide[31:0] : item.value;
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign do_pop     = head_pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    // two-entry queue, payload without reset
    always_ff @(posedge clk)
    begin
        if (do_push && do_pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_reg <= cmd_in;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= cmd_in;
            end
        end
        else if (do_pop)
        begin
            head_reg <= tail_reg;
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= cmd_in;
            end
            else
            begin
                tail_reg <= cmd_in;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpv_back.sv -----
// back: executes commands, one completed byte or status result per cycle while the result queue has room
`default_nettype none

module bpv_back
    import bpv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_head_t        head,
    output logic                  head_pop,
    input  wire logic [CAP_W-1:0] capacity,
    output logic                  res_push,
    output result_t               res,
    input  wire logic             res_full
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       partial_reg, partial_next;
    logic [2:0]       held_reg, held_next;
    op_t              op_reg, op_next;
    logic [31:0]      data_reg, data_next;
    logic [5:0]       cnt_reg, cnt_next;

    op_t         cur_op;
    logic [31:0] cur_data;
    logic [5:0]  cur_cnt;
    logic        go;
    logic        done;
    logic [3:0]  room;
    logic        take_all;
    logic [3:0]  take;
    logic [7:0]  bits_byte;
    logic [5:0]  rem;
    logic [31:0] shifted;
    logic [7:0]  tail;
    logic [7:0]  group;
    logic [7:0]  vbyte;
    logic [7:0]  vkeep;
    logic [7:0]  flush_byte;
    logic        at_cap;

    // operands come straight from the queue head on the first step
    assign cur_op   = (state_reg == ST_RUN) ? op_reg   : head.cmd.op;
    assign cur_data = (state_reg == ST_RUN) ? data_reg : head.cmd.data;
    assign cur_cnt  = (state_reg == ST_RUN) ? cnt_reg  : head.cmd.count;

    assign go       = ((state_reg == ST_RUN) || head.valid) && !res_full;
    assign head_pop = (state_reg == ST_IDLE) && head.valid && !res_full;

    always_comb
    begin
        room       = 4'd8 - {1'b0, held_reg};
        take_all   = (cur_cnt < {2'b00, room});
        take       = take_all ? cur_cnt[3:0] : room;
        bits_byte  = 8'(partial_reg << take) | (cur_data[31:24] >> (4'd8 - take));
        rem        = cur_cnt - {2'b00, room};
        shifted    = cur_data << room;
        tail       = shifted[31:24] >> (4'd8 - rem[3:0]);
        group      = {|cur_data[31:7], cur_data[6:0]};
        vbyte      = 8'(partial_reg << room) | (group >> held_reg);
        vkeep      = group & (8'hFF >> room);
        flush_byte = 8'(partial_reg << room);
        at_cap     = (pos_reg >= capacity);
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        partial_next = partial_reg;
        held_next    = held_reg;
        op_next      = cur_op;
        data_next    = data_reg;
        cnt_next     = cnt_reg;
        done         = 1'b1;
        res_push     = go;
        res.out_byte     = 8'd0;
        res.byte_valid   = 1'b0;
        res.out_position = 16'd0;
        res.last         = 1'b1;

        if (go)
        begin
            if (cur_op == OP_REWIND)
            begin
                pos_next = '0;
                ovf_next = 1'b0;
            end
            else if (ovf_reg)
            begin
                // dropped while overflowed
            end
            else
            begin
                case (cur_op)
                    OP_BITS:
                    begin
                        if (take_all)
                        begin
                            partial_next = bits_byte;
                            held_next    = held_reg + cur_cnt[2:0];
                        end
                        else if (at_cap)
                        begin
                            partial_next = 8'd0;
                            held_next    = 3'd0;
                            ovf_next     = 1'b1;
                        end
                        else
                        begin
                            res.out_byte     = bits_byte;
                            res.byte_valid   = 1'b1;
                            res.out_position = pos_reg[15:0];
                            pos_next         = pos_reg + POS_W'(1);
                            if (rem[5:3] == 3'd0)
                            begin
                                partial_next = tail;
                                held_next    = rem[2:0];
                            end
                            else
                            begin
                                partial_next = 8'd0;
                                held_next    = 3'd0;
                                data_next    = shifted;
                                cnt_next     = rem;
                                done         = 1'b0;
                                res.last     = 1'b0;
                            end
                        end
                    end
                    OP_VARINT:
                    begin
                        if (at_cap)
                        begin
                            partial_next = 8'd0;
                            held_next    = 3'd0;
                            ovf_next     = 1'b1;
                        end
                        else
                        begin
                            res.out_byte     = vbyte;
                            res.byte_valid   = 1'b1;
                            res.out_position = pos_reg[15:0];
                            pos_next         = pos_reg + POS_W'(1);
                            partial_next     = vkeep;
                            data_next        = cur_data >> 7;
                            if (cur_data[31:7] != 25'd0)
                            begin
                                done     = 1'b0;
                                res.last = 1'b0;
                            end
                        end
                    end
                    OP_FLUSH:
                    begin
                        if (held_reg == 3'd0)
                        begin
                            // nothing held, status only
                        end
                        else if (at_cap)
                        begin
                            partial_next = 8'd0;
                            held_next    = 3'd0;
                            ovf_next     = 1'b1;
                        end
                        else
                        begin
                            res.out_byte     = flush_byte;
                            res.byte_valid   = 1'b1;
                            res.out_position = pos_reg[15:0];
                            pos_next         = pos_reg + POS_W'(1);
                            partial_next     = 8'd0;
                            held_next        = 3'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            state_next = done ? ST_IDLE : ST_RUN;
        end
        res.status = ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
            partial_reg <= 8'd0;
            held_reg    <= 3'd0;
            op_reg      <= OP_BITS;
            data_reg    <= 32'd0;
            cnt_reg     <= 6'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
            partial_reg <= partial_next;
            held_reg    <= held_next;
            op_reg      <= op_next;
            data_reg    <= data_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bpv_out_queue.sv -----
// result queue: two entries between the back and the result ports
`default_nettype none

module bpv_out_queue
    import bpv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t din,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output result_t      dout
);

    logic [1:0] count_reg;
    result_t    head_reg;
    result_t    tail_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && do_pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_reg <= din;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= din;
            end
        end
        else if (do_pop)
        begin
            head_reg <= tail_reg;
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= din;
            end
            else
            begin
                tail_reg <= din;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bit_packer_with_varint_write_top.sv -----
// an item's first result passes the front queue, the back and the result queue to the ports
// throughput: one result per cycle from the back while the out queue has room; an item gives
//   1 to 5 results (a write of up to 32 bits completes at most 4 bytes, a varint at most 5)
// the back's single byte step per cycle sets the rate; two-entry queues sit on either side
// reset: async active low, clears both queues and the packer state, capacity returns to 65536
// no clearing pass: the block takes items from the first cycle after reset
`default_nettype none

`include "bit_packer_with_varint_write_top_macros.svh"

module bit_packer_with_varint_write_top
    import bpv_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item side
    input  wire logic             push,
    input  wire item_t            item,
    output logic                  full,
    // result side
    output logic                  empty,
    input  wire logic             pop,
    output result_t               result,
    // capacity register write channel
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_eff;
    cmd_head_t        head;
    logic             head_pop;
    logic             res_push;
    result_t          res;
    logic             res_full;

    // the capacity register takes a transfer in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    // values beyond the largest buffer behave as the largest buffer
    assign cap_eff = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;

    // front: classifies kinds, clamps and left-aligns write_bits data, queues commands
    bpv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .head     (head),
        .head_pop (head_pop)
    );

    // back: holds the partial byte, position and overflow flag, one byte step a cycle while the result queue has room
    bpv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_pop (head_pop),
        .capacity (cap_eff),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full)
    );

    // result queue decouples the back from a stalled consumer
    bpv_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .dout  (result)
    );

    // the back never offers a result the queue cannot take
    `BPV_ASSERT_NOW(a_no_push_when_full, res_full, !res_push, "result pushed into full queue")

    // a result without a byte carries zero byte and zero position
    `BPV_ASSERT_NOW(a_null_result_zero, !empty && !result.byte_valid,
        result.out_byte == 8'd0 && result.out_position == 16'd0, "null result not zeroed")

    // a byte is only ever emitted while not overflowed
    `BPV_ASSERT_NOW(a_byte_status_ok, !empty && result.byte_valid, !result.status,
        "byte emitted with overflow status")

    // a command leaves the front only when the back can produce its first result
    `BPV_ASSERT_NOW(a_pop_needs_room, head_pop, head.valid && !res_full,
        "command taken without room for its result")

endmodule

`default_nettype wire

// ----- tb/sv/bit_packer_with_varint_write_top_tb.sv -----
// self-checking testbench for the bit packer with varint write
`timescale 1ns / 1ps

module bit_packer_with_varint_write_top_tb
    import bpv_pkg::*;
();

    // mirrors the packer state and keeps the bytes the block still owes
    class packed_byte_board;
        logic [CAP_W-1:0] capacity;
        logic [7:0]       partial;
        int               held;
        logic [POS_W-1:0] write_pos;
        logic             overflowed;
        result_t          item_bytes[$];
        result_t          owed_bytes[$];
        int               failures;
        int               results_seen;
        int               overflow_reports;

        function new();
            capacity = CAP_RESET;
            partial = '0;
            held = 0;
            write_pos = '0;
            overflowed = 1'b0;
            failures = 0;
            results_seen = 0;
            overflow_reports = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        // status carries the overflow flag as it stands after this result
        function void log_byte(logic [7:0] b, logic v, logic [15:0] pos);
            result_t r;
            r.out_byte = b;
            r.byte_valid = v;
            r.out_position = pos;
            r.status = overflowed;
            r.last = 1'b0;
            item_bytes.push_back(r);
        endfunction

        // a completed byte past the capacity is dropped and overflow sticks
        function bit close_byte(logic [7:0] b);
            logic [CAP_W-1:0] limit;
            limit = (capacity > CAP_MAX) ? CAP_MAX : capacity;
            partial = '0;
            held = 0;
            if (write_pos >= limit) begin
                overflowed = 1'b1;
                return 1'b0;
            end
            log_byte(b, 1'b1, write_pos[15:0]);
            write_pos = write_pos + 1'b1;
            return 1'b1;
        endfunction

        // msb first, one bit at a time
        function bit append_bits(logic [31:0] v, int n);
            for (int i = n - 1; i >= 0; i--) begin
                partial = {partial[6:0], v[i]};
                held++;
                if (held == 8 && !close_byte(partial))
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // works out every result an accepted item causes
        function void note_item(item_t it);
            bit          ok;
            int          n;
            logic [31:0] rest;
            logic [7:0]  group;
            ok = 1'b1;
            item_bytes.delete();
            if (it.kind == OP_REWIND) begin
                // held bits survive a rewind
                write_pos = '0;
                overflowed = 1'b0;
            end
            else if (!overflowed) begin
                case (it.kind)
                    OP_BITS:
                    begin
                        n = (it.nbits > BITS_MAX) ? 32 : int'(it.nbits);
                        ok = append_bits(it.value, n);
                    end
                    OP_VARINT:
                    begin
                        // leb128: low group first, continuation bit on all but the final byte
                        rest = it.value;
                        do
                        begin
                            group = {1'b0, rest[6:0]};
                            rest = rest >> 7;
                            if (rest != 0)
                                group[7] = 1'b1;
                            ok = append_bits({24'd0, group}, 8);
                        end while (ok && rest != 0);
                    end
                    default:
                    begin
                        if (held != 0)
                            ok = close_byte(partial << (8 - held));
                    end
                endcase
            end
            if (item_bytes.size() == 0 || !ok)
                log_byte(8'h00, 1'b0, 16'h0000);
            item_bytes[item_bytes.size() - 1].last = 1'b1;
            foreach (item_bytes[i])
                owed_bytes.push_back(item_bytes[i]);
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (got.status)
                overflow_reports++;
            if (owed_bytes.size() == 0) begin
                $error("result transfer with nothing owed: %h", got);
                failures++;
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
                failures++;
            end
            if (got.out_position !== want.out_position) begin
                $error("out_position: expected %0d, got %0d",
                       want.out_position, got.out_position);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %b, got %b", want.status, got.status);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             push;
    item_t            item;
    logic             full;
    logic             empty;
    logic             pop;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    packed_byte_board board;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               items_sent;
    int               cap_writes;
    logic [CAP_W-1:0] phase_caps [6];

    bit_packer_with_varint_write_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, decided at the falling edge
    always @(negedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);

    // a result transfer happens at the rising edge with pop high and empty low
    always @(posedge clk)
        if (rst_n && pop && !empty)
            board.check_result(result);

    function automatic item_t make_item(op_t k, logic [31:0] v, logic [5:0] n);
        item_t it;
        it.kind = k;
        it.value = v;
        it.nbits = n;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    roll;
        roll = $urandom_range(0, 99);
        // unused fields of flush and rewind still get random content
        it.value = $urandom();
        it.nbits = 6'($urandom_range(0, 63));
        if (roll < 40) begin
            it.kind = OP_BITS;
            // mostly in-range counts, now and then an oversized one
            if ($urandom_range(0, 7) != 0)
                it.nbits = 6'($urandom_range(0, 32));
        end
        else if (roll < 70) begin
            // a random shift spreads the varint length over one to five bytes, zero included
            it.kind = OP_VARINT;
            it.value = it.value >> $urandom_range(0, 32);
        end
        else if (roll < 85)
            it.kind = OP_FLUSH;
        else
            it.kind = OP_REWIND;
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge with push left high
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        board.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    // capacity changes only once the block has drained
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        push <= 1'b0;
        while (board.owed_bytes.size() != 0)
            @(negedge clk);
        // every item yields a result, so a short settle is plenty
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_capacity(cap);
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        items_sent = 0;
        cap_writes = 0;
        send_idle_pct = 37;
        recv_idle_pct = 54;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and every operation at full capacity
        write_capacity(CAP_RESET);
        send_item(make_item(OP_BITS, 32'hFFFF_FFFF, 6'd0));    // zero bits: status only
        send_item(make_item(OP_BITS, 32'hFFFF_FFFF, 6'd32));
        send_item(make_item(OP_BITS, 32'h1234_5678, 6'd40));   // oversized count acts as 32
        send_item(make_item(OP_BITS, 32'hA5A5_A5A5, 6'd63));
        send_item(make_item(OP_BITS, 32'h0000_0001, 6'd1));
        send_item(make_item(OP_BITS, 32'h0000_0002, 6'd2));
        send_item(make_item(OP_FLUSH, 32'h0, 6'd0));           // partial byte padded out
        send_item(make_item(OP_FLUSH, 32'h0, 6'd0));           // nothing held
        send_item(make_item(OP_VARINT, 32'd0, 6'd0));          // zero gives one 0x00 byte
        send_item(make_item(OP_VARINT, 32'd127, 6'd0));
        send_item(make_item(OP_VARINT, 32'd128, 6'd0));
        send_item(make_item(OP_VARINT, 32'hFFFF_FFFF, 6'd0));  // five-byte varint
        send_item(make_item(OP_BITS, 32'h0000_0005, 6'd3));
        send_item(make_item(OP_VARINT, 32'd300, 6'd0));        // varint off byte alignment
        send_item(make_item(OP_REWIND, 32'h0, 6'd0));          // held bits kept
        send_item(make_item(OP_FLUSH, 32'h0, 6'd0));

        // overflow in the middle of an item, then writes while overflowed
        write_capacity(17'd2);
        send_item(make_item(OP_REWIND, 32'h0, 6'd0));
        send_item(make_item(OP_BITS, 32'h00AB_CDEF, 6'd24));
        send_item(make_item(OP_BITS, 32'h0000_00FF, 6'd8));
        send_item(make_item(OP_VARINT, 32'd5, 6'd0));
        send_item(make_item(OP_FLUSH, 32'h0, 6'd0));
        send_item(make_item(OP_REWIND, 32'h0, 6'd0));
        send_item(make_item(OP_VARINT, 32'h0000_3FFF, 6'd0));

        // no room at all
        write_capacity('0);
        send_item(make_item(OP_BITS, 32'h0000_0081, 6'd8));
        send_item(make_item(OP_REWIND, 32'h0, 6'd0));

        // above the maximum acts as the maximum
        write_capacity(17'h1FFFF);
        send_item(make_item(OP_BITS, 32'h0000_BEEF, 6'd16));

        // random phases: two per idling pattern, each at its own capacity
        phase_caps = '{17'd3, CAP_RESET, 17'd1, 17'h1FFFF, 17'd0, 17'd20};
        phase_caps[4] = CAP_W'($urandom_range(4, 40));
        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_capacity(phase_caps[p]);
            repeat (16) send_item(random_item());
        end

        // drain, then give the pipeline time to show any stray result
        push <= 1'b0;
        while (board.owed_bytes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("run covered %0d items over %0d capacity settings and three idling patterns",
                 items_sent, cap_writes);
        $display("%0d result transfers checked, %0d of them flagging overflow",
                 board.results_seen, board.overflow_reports);
        if (board.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
